// File: rtl/pasm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pasm_pkg: shared types and codes of the polynomial add/sub/mul unit
// Operation codes, the command queue entry and the engine state enum.
// ----------------------------------------------------------------------------
package pasm_pkg;

    localparam int RES_W   = 38;
    localparam int RPOW_W  = 6;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    // Compute command handed from front end to engine
    typedef struct packed {
        op_t        op;
        logic [4:0] deg_a;
        logic [4:0] deg_b;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_MAC  = 2'd2,
        ST_EMIT = 2'd3
    } eng_state_t;

endpackage

// File: rtl/pasm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pasm_front: input decode and command queue
// Loads go straight to the coefficient stores; compute items are queued.
// ----------------------------------------------------------------------------
module pasm_front #(
    parameter int MAX_DEGREE  = 31,
    parameter int COEFF_WIDTH = 16,
    parameter int AW          = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   action,
    input  logic                   poly_select,
    input  logic [4:0]             load_power,
    input  logic signed [15:0]     load_coefficient,
    input  logic [1:0]             operation,
    input  logic [4:0]             degree_a,
    input  logic [4:0]             degree_b,
    // engine has no command in progress
    input  logic                   eng_idle,
    // store write port
    output logic                   wr_a,
    output logic                   wr_b,
    output logic [AW-1:0]          wr_addr,
    output logic [COEFF_WIDTH-1:0] wr_data,
    // queue to engine
    output logic                   cmd_valid,
    input  logic                   cmd_ready,
    output pasm_pkg::cmd_t         cmd
);
    localparam int QD = 2;

    pasm_pkg::cmd_t q_reg [QD];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop, fits;
    logic [4:0] da, db;
    pasm_pkg::cmd_t new_cmd;

    // clamp degrees to the store size
    assign da = (32'(degree_a) > MAX_DEGREE) ? 5'(MAX_DEGREE) : degree_a;
    assign db = (32'(degree_b) > MAX_DEGREE) ? 5'(MAX_DEGREE) : degree_b;
    assign new_cmd = '{op: pasm_pkg::op_t'(operation), deg_a: da, deg_b: db};

    // a load waits until no queued or running compute can still read the stores
    assign in_ready = (cnt_reg != 2'd2)
                      && (action || ((cnt_reg == 2'd0) && eng_idle));
    assign fits     = (32'(load_power) <= MAX_DEGREE);
    assign wr_a     = in_valid && in_ready && !action && fits && !poly_select;
    assign wr_b     = in_valid && in_ready && !action && fits && poly_select;
    assign wr_addr  = AW'(load_power);
    assign wr_data  = COEFF_WIDTH'(load_coefficient);

    // operation 3 produces nothing and is dropped here
    assign push = in_valid && in_ready && action
                  && (operation != pasm_pkg::OP_NOP);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("cmd queue overflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2) else $error("cmd queue count bad");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> cnt_reg <= 2'd1 || $past(push)) else $error("queue pop bad");

endmodule

// File: rtl/pasm_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pasm_engine: coefficient stores and shared multiply-accumulate engine
// Walks result powers from the top down, reading one store pair per READ step.
// ----------------------------------------------------------------------------
module pasm_engine #(
    parameter int MAX_DEGREE  = 31,
    parameter int COEFF_WIDTH = 16,
    parameter int AW          = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_a,
    input  logic                              wr_b,
    input  logic [AW-1:0]                     wr_addr,
    input  logic [COEFF_WIDTH-1:0]            wr_data,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  pasm_pkg::cmd_t                    cmd,
    output logic                              eng_idle,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pasm_pkg::RPOW_W-1:0]       out_power,
    output logic signed [pasm_pkg::RES_W-1:0] out_coef,
    output logic                              out_last
);
    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int PW    = pasm_pkg::RPOW_W;
    localparam int RW    = pasm_pkg::RES_W;

    logic [COEFF_WIDTH-1:0] mem_a [DEPTH];
    logic [COEFF_WIDTH-1:0] mem_b [DEPTH];
    logic [COEFF_WIDTH-1:0] rd_a_reg, rd_b_reg;

    pasm_pkg::eng_state_t state_reg, state_next;
    pasm_pkg::op_t op_reg;
    logic [4:0]  da_reg, db_reg;
    logic [PW-1:0] p_reg, p_next;
    logic [5:0]  i_reg, i_next;
    logic [5:0]  j;
    logic        term_ok, term_ok_reg, last_term_reg, last_term;
    logic signed [RW-1:0] acc_reg, acc_next;
    logic signed [2*COEFF_WIDTH-1:0] prod;
    logic signed [RW-1:0] term;
    logic        obuf_full_reg;
    logic [PW-1:0] opow_reg;
    logic signed [RW-1:0] ocoef_reg;
    logic        load_out;

    // read addresses: mult walks i over A, j = p - i over B
    assign j = 6'(p_reg) - i_reg;
    always_comb
    begin
        if (op_reg == pasm_pkg::OP_MUL)
            term_ok = (i_reg <= 6'(da_reg)) && (6'(p_reg) >= i_reg)
                      && (j <= 6'(db_reg));
        else
            term_ok = 1'b1;
        last_term = (op_reg != pasm_pkg::OP_MUL) || (i_reg == 6'(da_reg));
    end

    // store writes and registered reads
    always_ff @(posedge clk)
    begin
        if (wr_a) mem_a[wr_addr] <= wr_data;
        if (wr_b) mem_b[wr_addr] <= wr_data;
        if (op_reg == pasm_pkg::OP_MUL)
        begin
            rd_a_reg <= mem_a[i_reg[AW-1:0]];
            rd_b_reg <= mem_b[j[AW-1:0]];
        end
        else
        begin
            rd_a_reg <= (p_reg <= PW'(da_reg)) ? mem_a[p_reg[AW-1:0]] : '0;
            rd_b_reg <= (p_reg <= PW'(db_reg)) ? mem_b[p_reg[AW-1:0]] : '0;
        end
        term_ok_reg   <= term_ok;
        last_term_reg <= last_term;
    end

    assign prod = $signed(rd_a_reg) * $signed(rd_b_reg);
    always_comb
    begin
        case (op_reg)
            pasm_pkg::OP_ADD: term = RW'($signed(rd_a_reg)) + RW'($signed(rd_b_reg));
            pasm_pkg::OP_SUB: term = RW'($signed(rd_a_reg)) - RW'($signed(rd_b_reg));
            pasm_pkg::OP_MUL: term = term_ok_reg ? RW'(prod) : '0;
            default:          term = '0;
        endcase
    end

    assign load_out = !obuf_full_reg || out_ready;
    assign eng_idle = (state_reg == pasm_pkg::ST_IDLE);

    // sequencer: READ issues reads, MAC accumulates, EMIT hands off a coefficient
    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        i_next     = i_reg;
        acc_next   = acc_reg;
        cmd_ready  = 1'b0;
        case (state_reg)
            pasm_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    p_next     = (cmd.op == pasm_pkg::OP_MUL)
                                 ? PW'(cmd.deg_a) + PW'(cmd.deg_b)
                                 : PW'((cmd.deg_a > cmd.deg_b) ? cmd.deg_a : cmd.deg_b);
                    i_next     = '0;
                    acc_next   = '0;
                    state_next = pasm_pkg::ST_READ;
                end
            end
            pasm_pkg::ST_READ:
            begin
                state_next = pasm_pkg::ST_MAC;
            end
            pasm_pkg::ST_MAC:
            begin
                acc_next = acc_reg + term;
                if (last_term_reg)
                    state_next = pasm_pkg::ST_EMIT;
                else
                begin
                    i_next     = i_reg + 6'd1;
                    state_next = pasm_pkg::ST_READ;
                end
            end
            pasm_pkg::ST_EMIT:
            begin
                if (load_out)
                begin
                    if (p_reg == '0)
                        state_next = pasm_pkg::ST_IDLE;
                    else
                    begin
                        p_next     = p_reg - PW'(1);
                        i_next     = '0;
                        acc_next   = '0;
                        state_next = pasm_pkg::ST_READ;
                    end
                end
            end
            default: state_next = pasm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pasm_pkg::ST_IDLE;
            obuf_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pasm_pkg::ST_EMIT && load_out)
                obuf_full_reg <= 1'b1;
            else if (out_ready)
                obuf_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        i_reg   <= i_next;
        acc_reg <= acc_next;
        if (state_reg == pasm_pkg::ST_IDLE && cmd_valid)
        begin
            op_reg <= cmd.op;
            da_reg <= cmd.deg_a;
            db_reg <= cmd.deg_b;
        end
        if (state_reg == pasm_pkg::ST_EMIT && load_out)
        begin
            opow_reg  <= p_reg;
            ocoef_reg <= acc_reg;
        end
    end

    assign out_valid = obuf_full_reg;
    assign out_power = opow_reg;
    assign out_coef  = ocoef_reg;
    assign out_last  = (opow_reg == '0);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(ocoef_reg) && out_valid)
        else $error("output dropped under stall");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> state_reg == pasm_pkg::ST_IDLE)
        else $error("command taken while busy");
    a_mac_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pasm_pkg::ST_MAC |-> $past(state_reg) == pasm_pkg::ST_READ)
        else $error("accumulate without read");

endmodule

// File: rtl/polynomial_add_sub_mul_unit.sv
`timescale 1ns / 1ps
// A load is written straight to its coefficient store, not queued. A compute
//   walks each result coefficient through READ and MAC, then hands it off in EMIT;
//   add/sub use one READ/MAC pair per coefficient, multiply one pair per power
//   of A. EMIT waits while the output register holds an untaken coefficient.
//   A load waits until every queued and running compute has finished.
// Reset (rst_n, async low) clears degrees, queue and sequencer; the stores
//   are not cleared and no clearing pass is run.
// ----------------------------------------------------------------------------
// polynomial_add_sub_mul_unit: polynomial add, subtract and multiply
// Front end decodes loads and queues compute commands for the engine.
// ----------------------------------------------------------------------------
module polynomial_add_sub_mul_unit #(
    parameter int MAX_DEGREE  = 31,
    parameter int COEFF_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] action, [1] poly_select, [6:2] load_power,
    // [22:7] load_coefficient, [24:23] operation
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] result_power, [43:6] result_coefficient
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_wdata
);
    localparam int AW = $clog2(MAX_DEGREE + 1);

    logic [4:0] degree_a_reg, degree_b_reg;
    logic wr_a, wr_b, cmd_valid, cmd_ready, eng_idle;
    logic [AW-1:0] wr_addr;
    logic [COEFF_WIDTH-1:0] wr_data;
    pasm_pkg::cmd_t cmd;
    logic [pasm_pkg::RPOW_W-1:0] rpow;
    logic signed [pasm_pkg::RES_W-1:0] rcoef;

    // degree registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_a_reg <= '0;
            degree_b_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'b0) degree_a_reg <= cfg_wdata;
            else                   degree_b_reg <= cfg_wdata;
        end
    end

    pasm_front #(.MAX_DEGREE(MAX_DEGREE), .COEFF_WIDTH(COEFF_WIDTH), .AW(AW)) u_front (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .action(s_axis_tdata[0]), .poly_select(s_axis_tdata[1]),
        .load_power(s_axis_tdata[6:2]), .load_coefficient(s_axis_tdata[22:7]),
        .operation(s_axis_tdata[24:23]),
        .degree_a(degree_a_reg), .degree_b(degree_b_reg),
        .eng_idle,
        .wr_a, .wr_b, .wr_addr, .wr_data,
        .cmd_valid, .cmd_ready, .cmd
    );

    pasm_engine #(.MAX_DEGREE(MAX_DEGREE), .COEFF_WIDTH(COEFF_WIDTH), .AW(AW)) u_engine (
        .clk, .rst_n,
        .wr_a, .wr_b, .wr_addr, .wr_data,
        .cmd_valid, .cmd_ready, .cmd,
        .eng_idle,
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_power(rpow), .out_coef(rcoef), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, rcoef, rpow};

endmodule
